### design/smo_pkg.sv
package smo_pkg;

  localparam int unsigned DefStackDepth = 64;
  localparam int unsigned DataW         = 32;

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_PALL = 3'd1,
    OP_PEEK = 3'd2,
    OP_POP  = 3'd3,
    OP_SWAP = 3'd4,
    OP_ADD  = 3'd5,
    OP_NOP  = 3'd6
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_PEEK_EMPTY = 3'd1,
    ST_POP_EMPTY  = 3'd2,
    ST_SWAP_SHORT = 3'd3,
    ST_ADD_SHORT  = 3'd4,
    ST_PUSH_FULL  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    RD_TOP      = 2'd0,
    RD_SECOND   = 2'd1,
    RD_PTR_NEXT = 2'd2
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_PUSH    = 2'd0,
    WR_SUM     = 2'd1,
    WR_SWAP_LO = 2'd2,
    WR_SWAP_HI = 2'd3
  } wr_sel_e;

  typedef struct packed {
    logic    in_ready;
    logic    emit;
    logic    emit_value;
    logic    emit_last;
    status_e emit_status;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    cap_top;
    logic    ptr_load;
    logic    ptr_dec;
  } cmd_t;

  typedef struct packed {
    logic    in_valid;
    opcode_e op;
    logic    empty;
    logic    short_stack;
    logic    full;
    logic    ptr_zero;
    logic    out_free;
  } stat_t;

endpackage

### design/smo_if.sv
interface smo_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic signed [31:0] push_value;

  modport source (output valid, opcode, push_value, input ready);
  modport sink   (input valid, opcode, push_value, output ready);
endinterface

interface smo_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic               value_valid;
  logic [2:0]         status;
  logic               last_result;

  modport source (output valid, result_value, value_valid, status, last_result, input ready);
  modport sink   (input valid, result_value, value_valid, status, last_result, output ready);
endinterface

### design/smo_ctrl.sv
module smo_ctrl
  import smo_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DISP = 7'b0000010,
    S_PEEK = 7'b0000100,
    S_RD2  = 7'b0001000,
    S_WB1  = 7'b0010000,
    S_WB2  = 7'b0100000,
    S_PALL = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d           = state_q;
    cmd_o.in_ready    = 1'b0;
    cmd_o.emit        = 1'b0;
    cmd_o.emit_value  = 1'b0;
    cmd_o.emit_last   = 1'b1;
    cmd_o.emit_status = ST_OK;
    cmd_o.rd_en       = 1'b0;
    cmd_o.rd_sel      = RD_TOP;
    cmd_o.wr_en       = 1'b0;
    cmd_o.wr_sel      = WR_PUSH;
    cmd_o.cnt_inc     = 1'b0;
    cmd_o.cnt_dec     = 1'b0;
    cmd_o.cap_top     = 1'b0;
    cmd_o.ptr_load    = 1'b0;
    cmd_o.ptr_dec     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (stat_i.in_valid) begin
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        case (stat_i.op)
          OP_PUSH: begin
            if (stat_i.out_free) begin
              cmd_o.emit        = 1'b1;
              cmd_o.emit_status = stat_i.full ? ST_PUSH_FULL : ST_OK;
              cmd_o.wr_en       = !stat_i.full;
              cmd_o.wr_sel      = WR_PUSH;
              cmd_o.cnt_inc     = !stat_i.full;
              state_d           = S_IDLE;
            end
          end
          OP_POP: begin
            if (stat_i.out_free) begin
              cmd_o.emit        = 1'b1;
              cmd_o.emit_status = stat_i.empty ? ST_POP_EMPTY : ST_OK;
              cmd_o.cnt_dec     = !stat_i.empty;
              state_d           = S_IDLE;
            end
          end
          OP_PEEK: begin
            if (!stat_i.empty) begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = RD_TOP;
              state_d      = S_PEEK;
            end else if (stat_i.out_free) begin
              cmd_o.emit        = 1'b1;
              cmd_o.emit_status = ST_PEEK_EMPTY;
              state_d           = S_IDLE;
            end
          end
          OP_SWAP, OP_ADD: begin
            if (!stat_i.short_stack) begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = RD_TOP;
              state_d      = S_RD2;
            end else if (stat_i.out_free) begin
              cmd_o.emit        = 1'b1;
              cmd_o.emit_status = (stat_i.op == OP_ADD) ? ST_ADD_SHORT : ST_SWAP_SHORT;
              state_d           = S_IDLE;
            end
          end
          OP_PALL: begin
            if (!stat_i.empty) begin
              cmd_o.rd_en    = 1'b1;
              cmd_o.rd_sel   = RD_TOP;
              cmd_o.ptr_load = 1'b1;
              state_d        = S_PALL;
            end else if (stat_i.out_free) begin
              cmd_o.emit = 1'b1;
              state_d    = S_IDLE;
            end
          end
          default: begin
            if (stat_i.out_free) begin
              cmd_o.emit = 1'b1;
              state_d    = S_IDLE;
            end
          end
        endcase
      end
      S_PEEK: begin
        if (stat_i.out_free) begin
          cmd_o.emit       = 1'b1;
          cmd_o.emit_value = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_RD2: begin
        cmd_o.cap_top = 1'b1;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = RD_SECOND;
        state_d       = S_WB1;
      end
      S_WB1: begin
        if (stat_i.op == OP_ADD) begin
          if (stat_i.out_free) begin
            cmd_o.wr_en   = 1'b1;
            cmd_o.wr_sel  = WR_SUM;
            cmd_o.cnt_dec = 1'b1;
            cmd_o.emit    = 1'b1;
            state_d       = S_IDLE;
          end
        end else begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = WR_SWAP_LO;
          state_d      = S_WB2;
        end
      end
      S_WB2: begin
        if (stat_i.out_free) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = WR_SWAP_HI;
          cmd_o.emit   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_PALL: begin
        if (stat_i.out_free) begin
          cmd_o.emit       = 1'b1;
          cmd_o.emit_value = 1'b1;
          cmd_o.emit_last  = stat_i.ptr_zero;
          if (stat_i.ptr_zero) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.rd_en   = 1'b1;
            cmd_o.rd_sel  = RD_PTR_NEXT;
            cmd_o.ptr_dec = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

### design/smo_dpath.sv
module smo_dpath
  import smo_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = DefStackDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  smo_in_if.sink     req_i,
  smo_out_if.source  rsp_o,
  input  cmd_t       cmd_i,
  output stat_t      stat_o
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  logic [DataW-1:0] mem [STACK_DEPTH];

  opcode_e          op_q;
  logic [DataW-1:0] val_q;
  logic [CW-1:0]    count_q, count_d;
  logic [AW-1:0]    ptr_q;
  logic [DataW-1:0] rd_q;
  logic [DataW-1:0] top_q;

  logic             out_valid_q;
  logic [DataW-1:0] out_value_q;
  logic             out_vv_q;
  status_e          out_status_q;
  logic             out_last_q;

  logic [CW-1:0]    cnt_m1, cnt_m2;
  logic [AW-1:0]    top_idx, second_idx, ptr_next;
  logic [AW-1:0]    raddr, waddr;
  logic [DataW-1:0] wdata;
  logic             out_free, full;

  assign cnt_m1     = count_q - CW'(1);
  assign cnt_m2     = count_q - CW'(2);
  assign top_idx    = cnt_m1[AW-1:0];
  assign second_idx = cnt_m2[AW-1:0];
  assign ptr_next   = ptr_q - AW'(1);
  assign full       = (count_q == CW'(STACK_DEPTH));
  assign out_free   = !out_valid_q || rsp_o.ready;

  assign req_i.ready = cmd_i.in_ready;

  assign stat_o.in_valid    = req_i.valid;
  assign stat_o.op          = op_q;
  assign stat_o.empty       = (count_q == '0);
  assign stat_o.short_stack = (count_q < CW'(2));
  assign stat_o.full        = full;
  assign stat_o.ptr_zero    = (ptr_q == '0);
  assign stat_o.out_free    = out_free;

  always_comb begin
    case (cmd_i.rd_sel)
      RD_TOP:      raddr = top_idx;
      RD_SECOND:   raddr = second_idx;
      RD_PTR_NEXT: raddr = ptr_next;
      default:     raddr = top_idx;
    endcase
  end

  always_comb begin
    case (cmd_i.wr_sel)
      WR_PUSH: begin
        waddr = count_q[AW-1:0];
        wdata = val_q;
      end
      WR_SUM: begin
        waddr = second_idx;
        wdata = top_q + rd_q;
      end
      WR_SWAP_LO: begin
        waddr = second_idx;
        wdata = top_q;
      end
      default: begin
        waddr = top_idx;
        wdata = rd_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && cmd_i.in_ready) begin
      val_q <= req_i.push_value;
    end
    if (cmd_i.cap_top) begin
      top_q <= rd_q;
    end
    if (cmd_i.ptr_load) begin
      ptr_q <= top_idx;
    end else if (cmd_i.ptr_dec) begin
      ptr_q <= ptr_next;
    end
    if (cmd_i.emit) begin
      out_value_q  <= cmd_i.emit_value ? rd_q : '0;
      out_vv_q     <= cmd_i.emit_value;
      out_status_q <= cmd_i.emit_status;
      out_last_q   <= cmd_i.emit_last;
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = cnt_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      op_q        <= OP_NOP;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (req_i.valid && cmd_i.in_ready) begin
        op_q <= opcode_e'(req_i.opcode);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.result_value = out_value_q;
  assign rsp_o.value_valid  = out_vv_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.last_result  = out_last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(STACK_DEPTH))
    else $error("entry count beyond stack depth");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free)
    else $error("result overwrites a waiting item");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_inc |=> count_q == $past(count_q) + CW'(1))
    else $error("push did not advance the count");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_dec |-> count_q != '0)
    else $error("pop on an empty stack");

endmodule

### design/stack_machine_ops.sv
// Channel   Role   Payload
// req_i     sink   opcode[2:0], push_value[31:0] signed
// rsp_o     source result_value[31:0] signed, value_valid, status[2:0], last_result
//
// One item at a time; the stack lives in a single-port-read, single-port-write
// memory with a registered read. Push, pop, no-op and errors answer at dispatch;
// peek reads the top; add reads two and writes the sum; swap reads two, writes
// both back. Print-all emits entries top first. Reset leaves the stack empty.
// A full output register stalls the sequencer; a new item is taken once the
// previous one has emitted its last result.
module stack_machine_ops
  import smo_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = DefStackDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  smo_in_if.sink    req_i,
  smo_out_if.source rsp_o
);

  cmd_t  cmd;
  stat_t stat;

  smo_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  smo_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .rsp_o  (rsp_o),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

endmodule
